// ===== hw/rtl/dmpc_pkg.sv =====
// Shared types and constants for the depth map to point cloud block.
`default_nettype none
package dmpc_pkg;

    typedef logic [47:0] pix_t;          // {variance, inverse depth}
    typedef pix_t [8:0] win_t;           // 3x3 window, row major, oldest first

    typedef struct packed {
        logic rd_en;
        logic shift_en;
    } ws_ctrl_t;

    localparam int DIM_W = 13;           // geometry arithmetic width

    localparam logic [1:0] ST_KEPT    = 2'd0;
    localparam logic [1:0] ST_VAR_REJ = 2'd1;
    localparam logic [1:0] ST_SUP_REJ = 2'd2;
    localparam logic [1:0] ST_NONPOS  = 2'd3;

    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_VAR_THRESHOLD = 3'd2;
    localparam logic [2:0] CFG_MIN_SUPPORT   = 3'd3;
    localparam logic [2:0] CFG_INV_FOCAL_X   = 3'd4;
    localparam logic [2:0] CFG_OFFSET_X      = 3'd5;
    localparam logic [2:0] CFG_INV_FOCAL_Y   = 3'd6;
    localparam logic [2:0] CFG_OFFSET_Y      = 3'd7;

endpackage
`default_nettype wire

// ===== hw/rtl/dmpc_window.sv =====
// Line store memory and the 3x3 pixel window.
`default_nettype none
module dmpc_window
    import dmpc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ws_ctrl_t      ctrl,
    input  wire logic [AW-1:0] addr,
    input  wire pix_t          pix,
    output win_t               win
);

    // entry holds {older row, newer row} of one column
    logic [95:0] mem [MAX_WIDTH];
    logic [95:0] rdata_reg;
    win_t        win_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
        if (ctrl.shift_en)
        begin
            mem[addr] <= {rdata_reg[47:0], pix};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (ctrl.shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= rdata_reg[95:48];
            win_reg[5] <= rdata_reg[47:0];
            win_reg[8] <= pix;
        end
    end

    assign win = win_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dmpc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module dmpc_div
#(
    parameter int NW = 56,
    localparam int CNTW = $clog2(NW)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [23:0]   den,
    output logic               done,
    output logic [NW-1:0]      quo
);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [23:0]     rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [24:0]     trial;
    logic            fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 24'(trial - {1'b0, den}) : trial[23:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/depth_map_to_point_cloud.sv =====
// Top level: raster back-projection of an inverse-depth map into 3D points.
`default_nettype none
// Pixels arrive in raster order as transactions on the input channel; one
// result transaction leaves for every interior pixel, judged when the pixel
// one row and one column past it arrives. The two previous rows live in a
// single-port line store memory addressed by column (one read, then one
// write back of the same entry); a 3x3 register window slides along them.
// An interior pixel then runs a sequencer: threshold*d^4 formed on a 32x24
// multiplier, one compare, the support count when min_support > 1, and
// three passes of a one-bit-per-cycle divider (z, x, y) with NW-bit
// quotients, each after a one-cycle start, NW being 56 at the default
// geometry. A rejected interior pixel skips the remaining steps, a border
// pixel skips the sequencer, and a result may wait for the output. Results
// wait in an output register, so the next pixel is taken while a result is
// still unclaimed. The user must write configuration only while the block
// is idle; the block does not enforce it. The line store needs no clearing
// after reset.
module depth_map_to_point_cloud
    import dmpc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [23:0] inv_depth,
    input  wire logic [23:0] inv_depth_var,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      point_x,
    output logic [31:0]      point_y,
    output logic [31:0]      point_z,
    output logic [1:0]       status,
    output logic [9:0]       pixel_col,
    output logic [9:0]       pixel_row,
    output logic             last
);

    localparam int CAW  = $clog2(MAX_WIDTH);
    localparam int RAW  = $clog2(MAX_HEIGHT);
    localparam int PW   = (CAW > RAW) ? CAW : RAW;
    localparam int AXW  = PW + 34;
    localparam int NW   = AXW + 12;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_VMUL  = 4'd3;
    localparam logic [3:0] S_VCMP  = 4'd4;
    localparam logic [3:0] S_SUP   = 4'd5;
    localparam logic [3:0] S_SUPD  = 4'd6;
    localparam logic [3:0] S_PROJ  = 4'd7;
    localparam logic [3:0] S_DZ    = 4'd8;
    localparam logic [3:0] S_DX    = 4'd9;
    localparam logic [3:0] S_DY    = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    // configuration registers
    logic [10:0] frame_width_reg, frame_height_reg;
    logic [31:0] var_threshold_reg;
    logic [3:0]  min_support_reg;
    logic [31:0] inv_focal_x_reg, offset_x_reg, inv_focal_y_reg, offset_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= 11'd640;
            frame_height_reg  <= 11'd480;
            var_threshold_reg <= 32'd65536;
            min_support_reg   <= 4'd0;
            inv_focal_x_reg   <= 32'd16777;
            offset_x_reg      <= 32'hFF33_3334;
            inv_focal_y_reg   <= 32'd16777;
            offset_y_reg      <= 32'hFF66_6667;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[10:0];
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[10:0];
                CFG_VAR_THRESHOLD: var_threshold_reg <= cfg_data;
                CFG_MIN_SUPPORT:   min_support_reg   <= cfg_data[3:0];
                CFG_INV_FOCAL_X:   inv_focal_x_reg   <= cfg_data;
                CFG_OFFSET_X:      offset_x_reg      <= cfg_data;
                CFG_INV_FOCAL_Y:   inv_focal_y_reg   <= cfg_data;
                CFG_OFFSET_Y:      offset_y_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [DIM_W-1:0] w_dim, h_dim;

    always_comb
    begin
        w_dim = DIM_W'(frame_width_reg);
        if (w_dim < DIM_W'(3))
        begin
            w_dim = DIM_W'(3);
        end
        else if (w_dim > DIM_W'(MAX_WIDTH))
        begin
            w_dim = DIM_W'(MAX_WIDTH);
        end
        h_dim = DIM_W'(frame_height_reg);
        if (h_dim < DIM_W'(3))
        begin
            h_dim = DIM_W'(3);
        end
        else if (h_dim > DIM_W'(MAX_HEIGHT))
        begin
            h_dim = DIM_W'(MAX_HEIGHT);
        end
    end

    // raster counters: wrap first if the geometry shrank, then advance
    logic [CAW-1:0]   col_reg;
    logic [RAW-1:0]   row_reg;
    logic [DIM_W-1:0] c_acc, r_acc, col_next, row_next;

    always_comb
    begin
        c_acc = DIM_W'(col_reg);
        r_acc = DIM_W'(row_reg);
        if (c_acc >= w_dim)
        begin
            c_acc = '0;
            r_acc = r_acc + 1'b1;
        end
        if (r_acc >= h_dim)
        begin
            r_acc = '0;
        end
        col_next = c_acc + 1'b1;
        row_next = r_acc;
        if (col_next >= w_dim)
        begin
            col_next = '0;
            row_next = r_acc + 1'b1;
            if (row_next >= h_dim)
            begin
                row_next = '0;
            end
        end
    end

    logic [3:0]     state_reg, state_next;
    logic           in_acc;
    pix_t           pix_reg;
    logic [CAW-1:0] c_reg;
    logic [RAW-1:0] r_reg;
    logic           last_reg;
    ws_ctrl_t       ws_ctrl;
    win_t           win;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;

    assign ws_ctrl.rd_en    = in_acc;
    assign ws_ctrl.shift_en = (state_reg == S_LOAD);

    dmpc_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ws_ctrl),
        .addr  (in_acc ? c_acc[CAW-1:0] : c_reg),
        .pix   (pix_reg),
        .win   (win)
    );

    // centre pixel
    logic [23:0] d_c, v_c;
    assign d_c = win[4][23:0];
    assign v_c = win[4][47:24];

    // threshold * d^4 by four passes of limb-wise multiply by d
    logic [3:0][31:0] acc_reg;
    logic [24:0]      carry_reg;
    logic [3:0]       mcnt_reg;
    logic [56:0]      limb_prod;

    assign limb_prod = 57'(acc_reg[mcnt_reg[1:0]]) * 57'(d_c) + 57'(carry_reg);

    // support count, one window cell a cycle
    logic [3:0]  k_reg;
    logic [3:0]  count_reg;
    logic [23:0] n_k, diff_k;
    logic [47:0] sq_k;
    logic        hit_k;

    assign n_k    = win[k_reg][23:0];
    assign diff_k = (n_k > d_c) ? (n_k - d_c) : (d_c - n_k);
    assign sq_k   = 48'(diff_k) * 48'(diff_k);
    assign hit_k  = (n_k != '0) && (sq_k < 48'({v_c, 21'b0}));

    // projection numerators
    logic signed [AXW-1:0] ax_reg, ay_reg, pos_x, pos_y;
    logic [AXW-1:0]        mag_x, mag_y;

    assign pos_x = AXW'(c_reg - 1'b1);
    assign pos_y = AXW'(r_reg - 1'b1);
    assign mag_x = ax_reg[AXW-1] ? AXW'(-ax_reg) : ax_reg;
    assign mag_y = ay_reg[AXW-1] ? AXW'(-ay_reg) : ay_reg;

    // divider
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [31:0]   sat_z, sat_x, sat_y;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = NW'(64'h10_0000_0000);
        if (state_reg == S_PROJ)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_DZ && div_done)
        begin
            div_start = 1'b1;
            div_num   = {mag_x, 12'b0};
        end
        else if (state_reg == S_DX && div_done)
        begin
            div_start = 1'b1;
            div_num   = {mag_y, 12'b0};
        end
    end

    dmpc_div #(
        .NW (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (d_c),
        .done  (div_done),
        .quo   (div_quo)
    );

    // saturate the quotient to the coordinate ranges
    logic q_over31, q_big;
    assign q_big    = |div_quo[NW-1:32];
    assign q_over31 = q_big || (div_quo[31] && (|div_quo[30:0]));
    assign sat_z    = q_big ? 32'hFFFF_FFFF : div_quo[31:0];

    always_comb
    begin
        if (ax_reg[AXW-1])
        begin
            sat_x = q_over31 ? 32'h8000_0000 : 32'(-div_quo[31:0]);
        end
        else
        begin
            sat_x = (q_big || div_quo[31]) ? 32'h7FFF_FFFF : div_quo[31:0];
        end
        if (ay_reg[AXW-1])
        begin
            sat_y = q_over31 ? 32'h8000_0000 : 32'(-div_quo[31:0]);
        end
        else
        begin
            sat_y = (q_big || div_quo[31]) ? 32'h7FFF_FFFF : div_quo[31:0];
        end
    end

    // sequencer
    logic [1:0]  stat_reg;
    logic [31:0] x_reg, y_reg, z_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_LOAD;
            S_LOAD:  state_next = (c_reg >= CAW'(2) && r_reg >= RAW'(2)) ? S_CHECK : S_IDLE;
            S_CHECK: state_next = (d_c == '0) ? S_EMIT : S_VMUL;
            S_VMUL:  if (mcnt_reg == 4'hF) state_next = S_VCMP;
            S_VCMP:
            begin
                if ({28'b0, v_c, 76'b0} > acc_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (min_support_reg > 4'd1)
                begin
                    state_next = S_SUP;
                end
                else
                begin
                    state_next = S_PROJ;
                end
            end
            S_SUP:   if (k_reg == 4'd8) state_next = S_SUPD;
            S_SUPD:  state_next = (count_reg < min_support_reg) ? S_EMIT : S_PROJ;
            S_PROJ:  state_next = S_DZ;
            S_DZ:    if (div_done) state_next = S_DX;
            S_DX:    if (div_done) state_next = S_DY;
            S_DY:    if (div_done) state_next = S_EMIT;
            S_EMIT:  if (!out_valid || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                col_reg <= col_next[CAW-1:0];
                row_reg <= row_next[RAW-1:0];
            end
            if (state_reg == S_EMIT && (!out_valid || out_ready))
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pix_reg  <= {inv_depth_var, inv_depth};
            c_reg    <= c_acc[CAW-1:0];
            r_reg    <= r_acc[RAW-1:0];
            last_reg <= (c_acc == w_dim - 1'b1) && (r_acc == h_dim - 1'b1);
        end
        unique case (state_reg)
            S_CHECK:
            begin
                stat_reg  <= (d_c == '0) ? ST_NONPOS : ST_KEPT;
                x_reg     <= '0;
                y_reg     <= '0;
                z_reg     <= '0;
                acc_reg   <= {96'b0, var_threshold_reg};
                carry_reg <= '0;
                mcnt_reg  <= '0;
            end
            S_VMUL:
            begin
                acc_reg[mcnt_reg[1:0]] <= limb_prod[31:0];
                carry_reg <= (mcnt_reg[1:0] == 2'd3) ? '0 : limb_prod[56:32];
                mcnt_reg  <= mcnt_reg + 1'b1;
            end
            S_VCMP:
            begin
                if ({28'b0, v_c, 76'b0} > acc_reg)
                begin
                    stat_reg <= ST_VAR_REJ;
                end
                k_reg     <= '0;
                count_reg <= '0;
            end
            S_SUP:
            begin
                k_reg <= k_reg + 1'b1;
                if (hit_k)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            S_SUPD:
            begin
                if (count_reg < min_support_reg)
                begin
                    stat_reg <= ST_SUP_REJ;
                end
            end
            S_PROJ:
            begin
                ax_reg <= AXW'(pos_x * AXW'($signed(inv_focal_x_reg)))
                          + AXW'($signed(offset_x_reg));
                ay_reg <= AXW'(pos_y * AXW'($signed(inv_focal_y_reg)))
                          + AXW'($signed(offset_y_reg));
            end
            S_DZ:    if (div_done) z_reg <= sat_z;
            S_DX:    if (div_done) x_reg <= sat_x;
            S_DY:    if (div_done) y_reg <= sat_y;
            S_EMIT:
            begin
                if (!out_valid || out_ready)
                begin
                    point_x   <= x_reg;
                    point_y   <= y_reg;
                    point_z   <= z_reg;
                    status    <= stat_reg;
                    pixel_col <= 10'(c_reg - 1'b1);
                    pixel_row <= 10'(r_reg - 1'b1);
                    last      <= last_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
